// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the converter RTL.
// Depends on a clock named clk and an active-high reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RTN_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define RTN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rtn_pkg.sv -----
// Shared types, constants and arithmetic helpers of the RGB to NV12 converter.
// No dependencies; used by every module of the block.
package rtn_pkg;

  // Field and counter widths.
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned OFF_W  = 23;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SUM_W  = 9;
  localparam int unsigned LINE_W = 3 * SUM_W;
  localparam int unsigned IN_W   = 24;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 2;

  // Parameter defaults.
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;

  // Register values after reset.
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 12'd1080;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 12'd1920;

  // Chroma weights (BT.601 studio range).
  localparam int U_KR = -38;
  localparam int U_KG = -74;
  localparam int U_KB = 112;
  localparam int V_KR = 112;
  localparam int V_KG = -94;
  localparam int V_KB = -18;

  // Sample kinds carried on tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_Y = 2'd0,
    KIND_U = 2'd1,
    KIND_V = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ORDER  = 2'd2
  } reg_idx_t;

  // Everything one pixel produces, handed to the output stage.
  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic [OFF_W-1:0] luma_off;
    logic [OFF_W-1:0] chroma_off;
    logic             has_chroma;
  } rec_t;

  // Clear bit 0, raise to at least two, cut to the even part of the limit.
  function automatic logic [SIZE_W-1:0] even_size(input logic [SIZE_W-1:0] v,
                                                  input int unsigned maxv);
    logic [SIZE_W-1:0] e;
    e = {v[SIZE_W-1:1], 1'b0};
    if (e < SIZE_W'(2)) e = SIZE_W'(2);
    if (32'(e) > maxv) e = SIZE_W'(maxv) & ~SIZE_W'(1);
    return e;
  endfunction

  // Y = ((66R + 129G + 25B + 128) >> 8) + 16, clamped to a byte.
  function automatic logic [PIX_W-1:0] luma(input logic [PIX_W-1:0] r,
                                           input logic [PIX_W-1:0] g,
                                           input logic [PIX_W-1:0] b);
    logic [15:0] s;
    logic [8:0]  t;
    s = 16'(r) * 16'd66 + 16'(g) * 16'd129 + 16'(b) * 16'd25 + 16'd128;
    t = {1'b0, s[15:8]} + 9'd16;
    return t[8] ? 8'hFF : t[7:0];
  endfunction

  // floor((kr*R + kg*G + kb*B + 128) / 256) + 128, clamped to a byte.
  function automatic logic [PIX_W-1:0] chroma_mix(input logic [PIX_W-1:0] cr,
                                                 input logic [PIX_W-1:0] cg,
                                                 input logic [PIX_W-1:0] cb,
                                                 input int kr,
                                                 input int kg,
                                                 input int kb);
    logic signed [17:0] t;
    t = 18'sd32896
        + 18'(kr) * $signed({10'b0, cr})
        + 18'(kg) * $signed({10'b0, cg})
        + 18'(kb) * $signed({10'b0, cb});
    if (t < 0) return 8'h00;
    else if (t[17:8] > 10'd255) return 8'hFF;
    else return t[15:8];
  endfunction

endpackage

// ----- rtl/rtn_line_store.sv -----
// Line store of even-row pair sums: one write port and one registered read port.
// Depends on rtn_pkg for the entry width.
module rtn_line_store #(
  parameter int unsigned DEPTH  = rtn_pkg::DEF_MAX_WIDTH / 2,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [rtn_pkg::LINE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [rtn_pkg::LINE_W-1:0]  rd_data
);

  logic [rtn_pkg::LINE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rtn_sample_emit.sv -----
// Output stage: holds one pixel's results and sends Y, then any U and V, one beat a cycle while m_tready is high.
// Depends on rtn_pkg for the result record and sample kinds.
`include "assert_macros.svh"

module rtn_sample_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rtn_pkg::rec_t               in_rec,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rtn_pkg::OUT_W-1:0]   m_tdata,  // sample_value, buffer_offset, zero pad
  output logic                        m_tlast,
  output logic [rtn_pkg::KIND_W-1:0]  m_tuser   // sample_kind
);

  typedef enum logic [2:0] {
    PH_Y = 3'b001,
    PH_U = 3'b010,
    PH_V = 3'b100
  } phase_t;

  phase_t                       phase;
  rtn_pkg::rec_t                rec;
  logic                         rec_valid;
  logic                         beat;
  logic                         final_beat;
  logic [rtn_pkg::PIX_W-1:0]    val;
  logic [rtn_pkg::OFF_W-1:0]    off;

  // The record is freed on the beat that carries its last sample.
  assign beat       = m_tvalid && m_tready;
  assign final_beat = (phase == PH_V) || ((phase == PH_Y) && !rec.has_chroma);
  assign in_ready   = !rec_valid || (m_tready && final_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      phase     <= PH_Y;
    end else if (in_valid && in_ready) begin
      rec_valid <= 1'b1;
      phase     <= PH_Y;
    end else if (beat && final_beat) begin
      rec_valid <= 1'b0;
      phase     <= PH_Y;
    end else if (beat) begin
      case (phase)
        PH_Y:    phase <= PH_U;
        PH_U:    phase <= PH_V;
        default: phase <= PH_Y;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rec <= in_rec;
    end
  end

  // Select the sample for the current beat.
  always_comb begin
    case (phase)
      PH_Y: begin
        m_tuser = rtn_pkg::KIND_Y;
        val     = rec.y;
        off     = rec.luma_off;
        m_tlast = !rec.has_chroma;
      end
      PH_U: begin
        m_tuser = rtn_pkg::KIND_U;
        val     = rec.u;
        off     = rec.chroma_off;
        m_tlast = 1'b0;
      end
      PH_V: begin
        m_tuser = rtn_pkg::KIND_V;
        val     = rec.v;
        off     = rec.chroma_off + rtn_pkg::OFF_W'(1);
        m_tlast = 1'b1;
      end
      default: begin
        m_tuser = rtn_pkg::KIND_Y;
        val     = '0;
        off     = '0;
        m_tlast = 1'b1;
      end
    endcase
  end

  assign m_tvalid = rec_valid;
  assign m_tdata  = {1'b0, off, val};

  // A U beat is always followed by its V beat, one byte further on.
  `RTN_ASSERT_NEXT(u_then_v, m_tvalid && m_tready && m_tuser == rtn_pkg::KIND_U, m_tvalid && m_tuser == rtn_pkg::KIND_V, "V sample does not follow U")
  `RTN_ASSERT_NEXT(v_offset, m_tvalid && m_tready && m_tuser == rtn_pkg::KIND_U, m_tdata[30:8] == $past(m_tdata[30:8]) + 23'd1, "V offset is not U offset plus one")
  // A pixel's results come without a gap.
  `RTN_ASSERT_NEXT(run_continues, m_tvalid && m_tready && !m_tlast, m_tvalid, "result run broken before last beat")

endmodule

// ----- rtl/rgb_to_nv12_converter.sv -----
// Top level of the RGB to NV12 converter: position tracking, colour math and config port.
// Depends on rtn_pkg, rtn_line_store, rtn_sample_emit and assert_macros.svh.
//
// Pixels enter one per beat in raster order (byte 0, green, byte 2) and each yields a
// BT.601 Y sample; the pixel at an odd row and odd column closes a 2x2 block and also
// yields U then V, so results leave at one per cycle while m_tready is high and a
// frame averages 1.5 output samples per pixel. The input takes a new pixel every cycle
// while the output keeps up; a block-closing pixel holds the output for its Y, U and
// V beats, and that output channel alone sets the sustained rate. Pair sums of the
// even row sit in a MAX_WIDTH/2 entry memory with one write and one registered read
// port; entries are only read after the row above wrote them, so the memory has no
// clearing pass and is usable right after reset. Writing the width or height restarts
// the frame; the block must be idle when configured.
`include "assert_macros.svh"

module rgb_to_nv12_converter #(
  parameter int unsigned MAX_WIDTH  = rtn_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rtn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [rtn_pkg::IN_W-1:0]    s_tdata,   // chan_first, chan_second, chan_third
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rtn_pkg::OUT_W-1:0]   m_tdata,   // sample_value, buffer_offset, zero pad
  output logic                        m_tlast,   // last_of_item
  output logic [rtn_pkg::KIND_W-1:0]  m_tuser,   // sample_kind
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rtn_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rtn_pkg::SIZE_W-1:0]  cfg_data
);

  localparam int unsigned LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned PW         = rtn_pkg::PIX_W;
  localparam int unsigned SW         = rtn_pkg::SUM_W;
  localparam int unsigned OW         = rtn_pkg::OFF_W;
  localparam int unsigned CW         = rtn_pkg::CNT_W;

  // Configuration.
  logic [rtn_pkg::SIZE_W-1:0] eff_w;
  logic [rtn_pkg::SIZE_W-1:0] eff_h;
  logic                       order;
  logic [OW-1:0]              area;

  // Frame position and offsets.
  logic [CW-1:0] col_cnt, col_cnt_next;
  logic [CW-1:0] row_cnt, row_cnt_next;
  logic [OW-1:0] luma_off, luma_off_next;
  logic [OW-1:0] chroma_rel, chroma_rel_next;
  logic [PW-1:0] left_r, left_g, left_b;

  // Input decode.
  logic          accept;
  logic [PW-1:0] px_r, px_g, px_b;
  logic [SW-1:0] pr, pg, pb;
  logic          block_end;
  logic          pair_write;
  logic [ADDR_W-1:0]           line_addr;
  logic [rtn_pkg::LINE_W-1:0]  line_rd;

  // Stage A: pixel and pair sums, line store read in flight.
  logic          a_valid;
  logic [PW-1:0] a_r, a_g, a_b;
  logic [SW-1:0] a_pr, a_pg, a_pb;
  logic          a_block;
  logic [OW-1:0] a_luma, a_crel;

  // Stage B: luma and block averages.
  logic          b_valid;
  logic          b_ready;
  logic [PW-1:0] b_y, b_sr, b_sg, b_sb;
  logic          b_block;
  logic [OW-1:0] b_luma, b_crel;
  logic [SW:0]   sum_r, sum_g, sum_b;

  rtn_pkg::rec_t rec;
  logic          emit_ready;

  assign cfg_ready = 1'b1;

  // Pixel decode: swap channels, form horizontal pair sums.
  assign accept    = s_tvalid && s_tready;
  assign px_r      = order ? s_tdata[23:16] : s_tdata[7:0];
  assign px_g      = s_tdata[15:8];
  assign px_b      = order ? s_tdata[7:0] : s_tdata[23:16];
  assign pr        = {1'b0, left_r} + {1'b0, px_r};
  assign pg        = {1'b0, left_g} + {1'b0, px_g};
  assign pb        = {1'b0, left_b} + {1'b0, px_b};
  assign block_end  = col_cnt[0] && row_cnt[0];
  assign pair_write = accept && col_cnt[0] && !row_cnt[0];
  assign line_addr  = ADDR_W'(col_cnt[CW-1:1]);

  // Next frame position after an accepted pixel.
  always_comb begin
    col_cnt_next    = col_cnt + CW'(1);
    row_cnt_next    = row_cnt;
    luma_off_next   = luma_off + OW'(1);
    chroma_rel_next = block_end ? chroma_rel + OW'(2) : chroma_rel;
    if ({1'b0, col_cnt} + (CW+1)'(1) >= {1'b0, eff_w}) begin
      col_cnt_next = '0;
      if ({1'b0, row_cnt} + (CW+1)'(1) >= {1'b0, eff_h}) begin
        row_cnt_next    = '0;
        luma_off_next   = '0;
        chroma_rel_next = '0;
      end else begin
        row_cnt_next = row_cnt + CW'(1);
      end
    end
  end

  // Position registers and configuration; a size write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w      <= rtn_pkg::even_size(rtn_pkg::RESET_WIDTH, MAX_WIDTH);
      eff_h      <= rtn_pkg::even_size(rtn_pkg::RESET_HEIGHT, MAX_HEIGHT);
      order      <= 1'b0;
      col_cnt    <= '0;
      row_cnt    <= '0;
      luma_off   <= '0;
      chroma_rel <= '0;
      left_r     <= '0;
      left_g     <= '0;
      left_b     <= '0;
    end else begin
      if (accept) begin
        col_cnt    <= col_cnt_next;
        row_cnt    <= row_cnt_next;
        luma_off   <= luma_off_next;
        chroma_rel <= chroma_rel_next;
        if (!col_cnt[0]) begin
          left_r <= px_r;
          left_g <= px_g;
          left_b <= px_b;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtn_pkg::REG_WIDTH: begin
            eff_w      <= rtn_pkg::even_size(cfg_data, MAX_WIDTH);
            col_cnt    <= '0;
            row_cnt    <= '0;
            luma_off   <= '0;
            chroma_rel <= '0;
          end
          rtn_pkg::REG_HEIGHT: begin
            eff_h      <= rtn_pkg::even_size(cfg_data, MAX_HEIGHT);
            col_cnt    <= '0;
            row_cnt    <= '0;
            luma_off   <= '0;
            chroma_rel <= '0;
          end
          rtn_pkg::REG_ORDER: begin
            order <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Start of the chroma plane, tracks the size registers.
  always_ff @(posedge clk) begin
    area <= OW'(eff_w * eff_h);
  end

  rtn_line_store #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (pair_write),
    .wr_addr (line_addr),
    .wr_data ({pb, pg, pr}),
    .rd_en   (accept && block_end),
    .rd_addr (line_addr),
    .rd_data (line_rd)
  );

  // Pipeline handshake; ready ripples back from the output stage.
  assign b_ready  = !b_valid || emit_ready;
  assign s_tready = !a_valid || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (accept) a_valid <= 1'b1;
      else if (b_ready) a_valid <= 1'b0;
      if (a_valid && b_ready) b_valid <= 1'b1;
      else if (emit_ready) b_valid <= 1'b0;
    end
  end

  // Stage A capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r     <= px_r;
      a_g     <= px_g;
      a_b     <= px_b;
      a_pr    <= pr;
      a_pg    <= pg;
      a_pb    <= pb;
      a_block <= block_end;
      a_luma  <= luma_off;
      a_crel  <= chroma_rel;
    end
  end

  // Block sums of four pixels, divided by four.
  assign sum_r = {1'b0, line_rd[SW-1:0]}      + {1'b0, a_pr};
  assign sum_g = {1'b0, line_rd[2*SW-1:SW]}   + {1'b0, a_pg};
  assign sum_b = {1'b0, line_rd[3*SW-1:2*SW]} + {1'b0, a_pb};

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      b_y     <= rtn_pkg::luma(a_r, a_g, a_b);
      b_sr    <= sum_r[SW:2];
      b_sg    <= sum_g[SW:2];
      b_sb    <= sum_b[SW:2];
      b_block <= a_block;
      b_luma  <= a_luma;
      b_crel  <= a_crel;
    end
  end

  // Chroma and final offsets go to the output stage.
  always_comb begin
    rec.y          = b_y;
    rec.u          = rtn_pkg::chroma_mix(b_sr, b_sg, b_sb,
                                         rtn_pkg::U_KR, rtn_pkg::U_KG, rtn_pkg::U_KB);
    rec.v          = rtn_pkg::chroma_mix(b_sr, b_sg, b_sb,
                                         rtn_pkg::V_KR, rtn_pkg::V_KG, rtn_pkg::V_KB);
    rec.luma_off   = b_luma;
    rec.chroma_off = area + b_crel;
    rec.has_chroma = b_block;
  end

  rtn_sample_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .in_ready (emit_ready),
    .in_rec   (rec),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // The column counter never reaches the row width.
  `RTN_ASSERT(col_in_row, col_cnt < eff_w, "column count outside the row")

endmodule
